// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Check that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

// ----- design/ndlre_pkg.sv -----
package ndlre_pkg;

  // Default sizes of the queue and of a packet
  localparam int QUEUE_DEPTH_DEF      = 64;
  localparam int MAX_PACKET_BYTES_DEF = 2048;

  // Field widths
  localparam int TIME_W     = 48;
  localparam int TAG_W      = 16;
  localparam int BYTES_W    = 12;
  localparam int DRAW_W     = 16;
  localparam int OWD_W      = 30;
  localparam int NPB_W      = 16;
  localparam int MQD_W      = 27;
  localparam int THR_W      = 17;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 30;

  // Input beat layout, lowest bit first
  localparam int IN_NOW_LSB   = 0;
  localparam int IN_TAG_LSB   = IN_NOW_LSB + TIME_W;
  localparam int IN_BYTES_LSB = IN_TAG_LSB + TAG_W;
  localparam int IN_LOSS_LSB  = IN_BYTES_LSB + BYTES_W;
  localparam int IN_DELAY_LSB = IN_LOSS_LSB + DRAW_W;
  localparam int IN_REO_LSB   = IN_DELAY_LSB + DRAW_W;
  localparam int IN_USED_W    = IN_REO_LSB + DRAW_W;
  localparam int IN_DATA_W    = ((IN_USED_W + 7) / 8) * 8;

  // Output beat layout: tag, bytes, sent_ahead, more_due, then queue_count
  localparam int OUT_TAG_LSB   = 0;
  localparam int OUT_BYTES_LSB = OUT_TAG_LSB + TAG_W;
  localparam int OUT_AHEAD_BIT = OUT_BYTES_LSB + BYTES_W;
  localparam int OUT_MORE_BIT  = OUT_AHEAD_BIT + 1;
  localparam int OUT_FIXED_W   = OUT_MORE_BIT + 1;

  // Register reset values
  localparam logic [OWD_W-1:0] OWD_RST      = OWD_W'(15000000);
  localparam logic [NPB_W-1:0] NPB_RST      = NPB_W'(80);
  localparam logic [MQD_W-1:0] MQD_RST      = MQD_W'(1000000);
  localparam logic [THR_W-1:0] LOSS_THR_RST = THR_W'(655);
  localparam logic [THR_W-1:0] REO_THR_RST  = THR_W'(655);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_WAY_DELAY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NS_PER_BYTE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_QDELAY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOSS_THR      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REORDER_THR   = 3'd4;

  typedef enum logic {
    OP_ARRIVE  = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_QUEUED   = 3'd0,
    ST_LOST     = 3'd1,
    ST_FULL     = 3'd2,
    ST_RELEASED = 3'd3,
    ST_NONE_DUE = 3'd4
  } status_e;

  // Controls from the sequencer to the departure unit
  typedef struct packed {
    logic load;      // capture products of the arriving packet
    logic calc;      // form base time and extra delay
    logic use_last;  // queue not empty: tail departure bounds the base
  } dc_ctrl_t;

endpackage

// ----- design/ndlre_dep_calc.sv -----
module ndlre_dep_calc (
  input  logic                             clk_i,
  input  ndlre_pkg::dc_ctrl_t              ctrl_i,
  input  logic [ndlre_pkg::BYTES_W-1:0]    bytes_i,
  input  logic [ndlre_pkg::NPB_W-1:0]      ns_per_byte_i,
  input  logic [ndlre_pkg::DRAW_W-1:0]     delay_draw_i,
  input  logic [ndlre_pkg::MQD_W-1:0]      max_qdelay_i,
  input  logic [ndlre_pkg::TIME_W-1:0]     now_i,
  input  logic [ndlre_pkg::OWD_W-1:0]      one_way_delay_i,
  input  logic [ndlre_pkg::TIME_W-1:0]     last_dep_i,
  output logic [ndlre_pkg::TIME_W-1:0]     dep_o
);

  localparam int ProdBW = ndlre_pkg::BYTES_W + ndlre_pkg::NPB_W;
  localparam int ProdDW = ndlre_pkg::DRAW_W + ndlre_pkg::MQD_W;
  localparam int BaseW  = ndlre_pkg::TIME_W + 1;
  localparam int ExtraW = ProdBW + 1;
  localparam int SumW   = BaseW + 1;

  logic [ProdBW-1:0] prod_b_q;
  logic [ProdDW-1:0] prod_d_q;
  logic [BaseW-1:0]  base_q, base_d;
  logic [ExtraW-1:0] extra_q, extra_d;
  logic [BaseW-1:0]  arr_sum;
  logic [BaseW-1:0]  last_ext;
  logic [SumW-1:0]   dep_sum;

  // Serialization time and random queuing delay, one multiplier each
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      prod_b_q <= bytes_i * ns_per_byte_i;
      prod_d_q <= delay_draw_i * max_qdelay_i;
    end
  end

  // Base time: arrival plus propagation, not before the tail departs
  always_comb begin
    arr_sum  = {1'b0, now_i} + BaseW'(one_way_delay_i);
    last_ext = BaseW'(last_dep_i);
    base_d   = (ctrl_i.use_last && (last_ext > arr_sum)) ? last_ext : arr_sum;
    extra_d  = ExtraW'(prod_b_q) + ExtraW'(prod_d_q[ProdDW-1:16]);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.calc) begin
      base_q  <= base_d;
      extra_q <= extra_d;
    end
  end

  // Final add, saturate at the top of the time range
  always_comb begin
    dep_sum = SumW'(base_q) + SumW'(extra_q);
    dep_o   = (dep_sum[SumW-1:ndlre_pkg::TIME_W] != '0) ? '1
                                                        : dep_sum[ndlre_pkg::TIME_W-1:0];
  end

endmodule

// ----- design/network_delay_loss_reorder_emulator.sv -----
// Link impairment queue: delays, drops and reorders packet events.
// Input stream (s_axis_*): one beat per event. tuser = operation (0 arrival,
// 1 release check); tdata carries now_ns, packet_tag, packet_bytes and the
// loss, delay and reorder draws. Each accepted beat yields exactly one
// output beat (m_axis_*): tuser = status, tdata = tag, bytes, sent_ahead,
// more_due and queue_count.
// Flow: a release check or a lost/full arrival goes from accept through S_READ
// to the result register; a queued arrival passes S_READ and then S_DEP, the
// extra state being the final departure add. The queue memory is read at the
// accept edge. The next beat is accepted in the cycle after the result is
// registered.
// The output register holds one finished result; while the receiver stalls,
// the block still accepts one more beat and works it up to the point of
// committing, then waits there until the output register is free.
// Reset empties the queue (head, tail and count to zero) and loads the
// default link settings; no memory clearing is needed.
// Configuration writes (cfg_we_i) take effect at once and are meant for
// idle periods only.
module network_delay_loss_reorder_emulator #(
  parameter int  QUEUE_DEPTH      = ndlre_pkg::QUEUE_DEPTH_DEF,
  parameter int  MAX_PACKET_BYTES = ndlre_pkg::MAX_PACKET_BYTES_DEF,
  localparam int CntW             = $clog2(QUEUE_DEPTH + 1),
  localparam int OutDataW         = ((ndlre_pkg::OUT_FIXED_W + CntW + 7) / 8) * 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // tuser: operation
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // tdata: now_ns, packet_tag, packet_bytes, loss_draw, delay_draw, reorder_draw
  input  logic [ndlre_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  input  logic                                s_axis_tuser_i,
  // tuser: status
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // tdata: out_tag, out_bytes, sent_ahead, more_due, queue_count
  output logic [OutDataW-1:0]                 m_axis_tdata_o,
  output logic [ndlre_pkg::STATUS_W-1:0]      m_axis_tuser_o,
  input  logic                                cfg_we_i,
  input  logic [ndlre_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  logic [ndlre_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  localparam int IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [IdxW-1:0] LastSlot = IdxW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt  = CntW'(QUEUE_DEPTH);
  localparam logic [16:0]     MaxBytes = 17'(MAX_PACKET_BYTES);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_DEP  = 2'd2;

  typedef struct packed {
    logic [ndlre_pkg::TIME_W-1:0]  dep;
    logic [ndlre_pkg::BYTES_W-1:0] bytes;
    logic [ndlre_pkg::TAG_W-1:0]   tag;
  } entry_t;

  function automatic logic [IdxW-1:0] next_slot(input logic [IdxW-1:0] i);
    return (i == LastSlot) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] prev_slot(input logic [IdxW-1:0] i);
    return (i == '0) ? LastSlot : i - 1'b1;
  endfunction

  // Link settings
  logic [ndlre_pkg::OWD_W-1:0] owd_q;
  logic [ndlre_pkg::NPB_W-1:0] npb_q;
  logic [ndlre_pkg::MQD_W-1:0] mqd_q;
  logic [ndlre_pkg::THR_W-1:0] loss_thr_q;
  logic [ndlre_pkg::THR_W-1:0] reo_thr_q;

  // Sequencer and queue pointers
  logic [1:0]      state_q, state_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [IdxW-1:0] tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;

  // Captured event
  ndlre_pkg::op_e                op_q;
  logic [ndlre_pkg::TIME_W-1:0]  now_q;
  logic [ndlre_pkg::TAG_W-1:0]   tag_q;
  logic [ndlre_pkg::BYTES_W-1:0] bytes_q;
  logic [ndlre_pkg::DRAW_W-1:0]  loss_draw_q;
  logic [ndlre_pkg::DRAW_W-1:0]  reo_draw_q;

  // Queue memory
  entry_t          mem_q [QUEUE_DEPTH];
  entry_t          rd_a_q, rd_b_q;
  logic [IdxW-1:0] rd_a_addr, rd_b_addr;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  entry_t          mem_wdata;

  // Result register
  logic                          out_valid_q, out_valid_d;
  ndlre_pkg::status_e            out_status_q, out_status_d;
  logic [ndlre_pkg::TAG_W-1:0]   out_tag_q, out_tag_d;
  logic [ndlre_pkg::BYTES_W-1:0] out_bytes_q, out_bytes_d;
  logic                          out_ahead_q, out_ahead_d;
  logic                          out_more_q, out_more_d;
  logic [CntW-1:0]               out_count_q, out_count_d;
  logic                          out_load;

  logic                          in_accept;
  ndlre_pkg::op_e                in_op;
  logic [ndlre_pkg::BYTES_W-1:0] in_bytes;
  logic [ndlre_pkg::BYTES_W-1:0] in_bytes_sat;
  logic                          out_free;
  logic                          lost, full, none_due, reorder;
  ndlre_pkg::dc_ctrl_t           dc_ctrl;
  logic [ndlre_pkg::TIME_W-1:0]  dep;

  assign in_op     = ndlre_pkg::op_e'(s_axis_tuser_i);
  assign in_bytes  = s_axis_tdata_i[ndlre_pkg::IN_BYTES_LSB +: ndlre_pkg::BYTES_W];
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !out_valid_q || m_axis_tready_i;

  // Clamp oversized packets
  assign in_bytes_sat = (17'(in_bytes) > MaxBytes) ? MaxBytes[ndlre_pkg::BYTES_W-1:0]
                                                   : in_bytes;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owd_q      <= ndlre_pkg::OWD_RST;
      npb_q      <= ndlre_pkg::NPB_RST;
      mqd_q      <= ndlre_pkg::MQD_RST;
      loss_thr_q <= ndlre_pkg::LOSS_THR_RST;
      reo_thr_q  <= ndlre_pkg::REO_THR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        ndlre_pkg::CFG_ONE_WAY_DELAY: owd_q <= cfg_wdata_i[ndlre_pkg::OWD_W-1:0];
        ndlre_pkg::CFG_NS_PER_BYTE:   npb_q <= cfg_wdata_i[ndlre_pkg::NPB_W-1:0];
        ndlre_pkg::CFG_MAX_QDELAY:    mqd_q <= cfg_wdata_i[ndlre_pkg::MQD_W-1:0];
        ndlre_pkg::CFG_LOSS_THR:      loss_thr_q <= cfg_wdata_i[ndlre_pkg::THR_W-1:0];
        ndlre_pkg::CFG_REORDER_THR:   reo_thr_q <= cfg_wdata_i[ndlre_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the event
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q        <= in_op;
      now_q       <= s_axis_tdata_i[ndlre_pkg::IN_NOW_LSB +: ndlre_pkg::TIME_W];
      tag_q       <= s_axis_tdata_i[ndlre_pkg::IN_TAG_LSB +: ndlre_pkg::TAG_W];
      bytes_q     <= in_bytes_sat;
      loss_draw_q <= s_axis_tdata_i[ndlre_pkg::IN_LOSS_LSB +: ndlre_pkg::DRAW_W];
      reo_draw_q  <= s_axis_tdata_i[ndlre_pkg::IN_REO_LSB +: ndlre_pkg::DRAW_W];
    end
  end

  // Arrival reads the tail entry, release reads head and the one behind it
  assign rd_a_addr = (in_op == ndlre_pkg::OP_RELEASE) ? head_q : prev_slot(tail_q);
  assign rd_b_addr = next_slot(head_q);

  // Queue memory: one write port, two registered read ports. Writes commit
  // before the next event is accepted, so reads never see stale entries.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (in_accept) begin
      rd_a_q <= mem_q[rd_a_addr];
      rd_b_q <= mem_q[rd_b_addr];
    end
  end

  // Event decisions from the captured draws and the read entries
  always_comb begin
    lost     = 17'(loss_draw_q) < loss_thr_q;
    full     = count_q == FullCnt;
    none_due = (count_q == '0) || (rd_a_q.dep > now_q);
    reorder  = (17'(reo_draw_q) < reo_thr_q) && (count_q >= CntW'(2));
  end

  assign dc_ctrl.load     = in_accept;
  assign dc_ctrl.calc     = (state_q == S_READ);
  assign dc_ctrl.use_last = (count_q != '0);

  ndlre_dep_calc u_dep_calc (
    .clk_i           (clk_i),
    .ctrl_i          (dc_ctrl),
    .bytes_i         (in_bytes_sat),
    .ns_per_byte_i   (npb_q),
    .delay_draw_i    (s_axis_tdata_i[ndlre_pkg::IN_DELAY_LSB +: ndlre_pkg::DRAW_W]),
    .max_qdelay_i    (mqd_q),
    .now_i           (now_q),
    .one_way_delay_i (owd_q),
    .last_dep_i      (rd_a_q.dep),
    .dep_o           (dep)
  );

  // Sequencer: read, decide, commit when the result register is free
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    count_d      = count_q;
    mem_we       = 1'b0;
    mem_waddr    = tail_q;
    mem_wdata    = rd_a_q;
    out_load     = 1'b0;
    out_status_d = ndlre_pkg::ST_NONE_DUE;
    out_tag_d    = '0;
    out_bytes_d  = '0;
    out_ahead_d  = 1'b0;
    out_more_d   = 1'b0;
    out_count_d  = count_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (op_q == ndlre_pkg::OP_ARRIVE) begin
          if (!lost && !full) begin
            state_d = S_DEP;
          end else if (out_free) begin
            out_load     = 1'b1;
            out_status_d = lost ? ndlre_pkg::ST_LOST : ndlre_pkg::ST_FULL;
            state_d      = S_IDLE;
          end
        end else if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          if (none_due) begin
            out_status_d = ndlre_pkg::ST_NONE_DUE;
          end else begin
            out_status_d = ndlre_pkg::ST_RELEASED;
            head_d       = next_slot(head_q);
            count_d      = count_q - 1'b1;
            out_count_d  = count_d;
            if (reorder) begin
              // Send the second packet, move the held-back head into its slot
              out_tag_d   = rd_b_q.tag;
              out_bytes_d = rd_b_q.bytes;
              out_ahead_d = 1'b1;
              out_more_d  = 1'b1;
              mem_we      = 1'b1;
              mem_waddr   = next_slot(head_q);
              mem_wdata   = rd_a_q;
            end else begin
              out_tag_d   = rd_a_q.tag;
              out_bytes_d = rd_a_q.bytes;
              out_more_d  = (count_q >= CntW'(2)) && (rd_b_q.dep <= now_q);
            end
          end
        end
      end
      S_DEP: begin
        if (out_free) begin
          mem_we          = 1'b1;
          mem_waddr       = tail_q;
          mem_wdata.dep   = dep;
          mem_wdata.bytes = bytes_q;
          mem_wdata.tag   = tag_q;
          tail_d          = next_slot(tail_q);
          count_d         = count_q + 1'b1;
          out_load        = 1'b1;
          out_status_d    = ndlre_pkg::ST_QUEUED;
          out_count_d     = count_d;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign s_axis_tready_o = (state_q == S_IDLE);

  // Result valid: set on load, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= out_status_d;
      out_tag_q    <= out_tag_d;
      out_bytes_q  <= out_bytes_d;
      out_ahead_q  <= out_ahead_d;
      out_more_q   <= out_more_d;
      out_count_q  <= out_count_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = OutDataW'({out_count_q, out_more_q, out_ahead_q,
                                      out_bytes_q, out_tag_q});

endmodule

// ----- design/ndlre_checker.sv -----
`include "assert_macros.svh"

module ndlre_checker #(
  parameter int  QUEUE_DEPTH = ndlre_pkg::QUEUE_DEPTH_DEF,
  localparam int CntW        = $clog2(QUEUE_DEPTH + 1),
  localparam int OutDataW    = ((ndlre_pkg::OUT_FIXED_W + CntW + 7) / 8) * 8
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid_i,
  input logic                           m_axis_tready_i,
  input logic [OutDataW-1:0]            m_axis_tdata_i,
  input logic [ndlre_pkg::STATUS_W-1:0] m_axis_tuser_i
);

  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  logic [CntW-1:0]                          count;
  logic                                     released;
  logic                                     out_stall;
  logic [OutDataW+ndlre_pkg::STATUS_W-1:0]  out_beat;
  logic                                     fields_set;
  logic                                     count_bad;

  assign count      = m_axis_tdata_i[ndlre_pkg::OUT_FIXED_W +: CntW];
  assign released   = (m_axis_tuser_i == ndlre_pkg::ST_RELEASED);
  assign out_stall  = m_axis_tvalid_i && !m_axis_tready_i;
  assign out_beat   = {m_axis_tuser_i, m_axis_tdata_i};
  assign fields_set = (m_axis_tdata_i[ndlre_pkg::OUT_FIXED_W-1:0] != '0);
  assign count_bad  = ((m_axis_tuser_i == ndlre_pkg::ST_QUEUED) && (count == '0)) ||
                      ((m_axis_tuser_i == ndlre_pkg::ST_FULL) && (count != FullCnt));

  // A stalled result beat holds
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_stall |=> (m_axis_tvalid_i && $stable(out_beat)))

  // Packet fields and flags stay zero unless a packet was released
  `ASSERT_NEVER(a_fields_zero, clk_i, rst_ni, m_axis_tvalid_i && !released && fields_set)

  // The queue never holds more than its depth
  `ASSERT_NEVER(a_count_bound, clk_i, rst_ni, m_axis_tvalid_i && (count > FullCnt))

  // A queued packet leaves the queue non-empty; a full drop reports a full queue
  `ASSERT_NEVER(a_count_status, clk_i, rst_ni, m_axis_tvalid_i && count_bad)

endmodule

bind network_delay_loss_reorder_emulator ndlre_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_ndlre_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o)
);
